>>> rtl/mtwc_pkg.sv
package mtwc_pkg;

    localparam int unsigned CODE_W = 24;
    localparam int unsigned BYTE_W = 8;

    localparam logic [BYTE_W-1:0] SS2_BYTE = 8'h8E;
    localparam logic [BYTE_W-1:0] SS3_BYTE = 8'h8F;

    typedef enum logic [1:0] {
        MODE_EUC_JK = 2'd0,
        MODE_EUC_TW = 2'd1,
        MODE_EUC_CN = 2'd2,
        MODE_UTF8   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        K_IDLE    = 3'd0,
        K_SS2_ONE = 3'd1,
        K_SS2_TW  = 3'd2,
        K_SS2_CN  = 3'd3,
        K_SS3     = 3'd4,
        K_EUC2    = 3'd5,
        K_UTF2    = 3'd6,
        K_UTF3    = 3'd7
    } t_kind;

    typedef struct packed {
        logic              has_char;
        logic              truncated;
        logic              has_end;
        logic [CODE_W-1:0] code;
    } t_job;

endpackage

>>> rtl/mtwc_front.sv
module mtwc_front
    import mtwc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_data,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_eob,
    input  logic              i_full,
    output logic              o_push,
    output t_job              o_job
);

    t_mode             r_mode;
    logic [1:0]        r_rem,   n_rem;
    logic [CODE_W-1:0] r_acc,   n_acc;
    t_kind             r_kind,  n_kind;
    logic              r_ended, n_ended;
    logic              w_accept;

    function automatic logic [CODE_W-1:0] merge_bits(
        input t_kind             kind,
        input logic [1:0]        rem,
        input logic [BYTE_W-1:0] b
    );
        logic [CODE_W-1:0] res;
        res = '0;
        case (kind)
            K_SS2_ONE: res = {16'b0, b};
            K_SS2_TW:  res = (rem == 2'd2) ? {10'b0, b[5:0], 8'b0} : {16'b0, b};
            K_SS2_CN: begin
                if (rem == 2'd3) begin
                    res = {b, 16'b0};
                end else if (rem == 2'd2) begin
                    res = {8'b0, b, 8'b0};
                end else begin
                    res = {16'b0, b};
                end
            end
            K_SS3:     res = (rem == 2'd2) ? {8'b0, b, 8'b0} : {18'b0, b[5:0]};
            K_EUC2:    res = {16'b0, b};
            K_UTF2:    res = {18'b0, b[5:0]};
            K_UTF3:    res = (rem == 2'd2) ? {12'b0, b[5:0], 6'b0} : {18'b0, b[5:0]};
            default:   res = '0;
        endcase
        return res;
    endfunction

    assign w_accept = i_valid && !i_full;

    always_comb begin
        logic nul_end;
        n_rem   = r_rem;
        n_acc   = r_acc;
        n_kind  = r_kind;
        n_ended = r_ended;
        nul_end = 1'b0;
        o_job   = '0;
        if (r_ended) begin
            if (i_eob) begin
                n_ended = 1'b0;
            end
        end else begin
            if (r_rem != 2'd0) begin
                n_acc = r_acc | merge_bits(r_kind, r_rem, i_byte);
                n_rem = r_rem - 2'd1;
                if (n_rem == 2'd0) begin
                    o_job.has_char = 1'b1;
                    o_job.code     = n_acc;
                    n_acc          = '0;
                    n_kind         = K_IDLE;
                end
            end else if (i_byte == 8'h00) begin
                o_job.has_end = 1'b1;
                nul_end       = 1'b1;
                n_acc         = '0;
                n_kind        = K_IDLE;
                n_ended       = !i_eob;
            end else if (r_mode == MODE_UTF8) begin
                if (!i_byte[7]) begin
                    o_job.has_char = 1'b1;
                    o_job.code     = {16'b0, i_byte};
                end else if (i_byte[7:5] == 3'b110) begin
                    n_kind = K_UTF2;
                    n_rem  = 2'd1;
                    n_acc  = {13'b0, i_byte[4:0], 6'b0};
                end else if (i_byte[7:5] == 3'b111) begin
                    n_kind = K_UTF3;
                    n_rem  = 2'd2;
                    n_acc  = {8'b0, i_byte[3:0], 12'b0};
                end
            end else if (i_byte == SS2_BYTE) begin
                n_acc = '0;
                if (r_mode == MODE_EUC_JK) begin
                    n_kind = K_SS2_ONE;
                    n_rem  = 2'd1;
                end else if (r_mode == MODE_EUC_TW) begin
                    n_kind = K_SS2_TW;
                    n_rem  = 2'd2;
                end else begin
                    n_kind = K_SS2_CN;
                    n_rem  = 2'd3;
                end
            end else if (i_byte == SS3_BYTE) begin
                n_kind = K_SS3;
                n_rem  = 2'd2;
                n_acc  = '0;
            end else if (i_byte[7]) begin
                n_kind = K_EUC2;
                n_rem  = 2'd1;
                n_acc  = {8'b0, i_byte, 8'b0};
            end else begin
                o_job.has_char = 1'b1;
                o_job.code     = {16'b0, i_byte};
            end

            if (i_eob && !nul_end) begin
                if (n_rem != 2'd0) begin
                    o_job.has_char  = 1'b1;
                    o_job.truncated = 1'b1;
                    o_job.code      = n_acc;
                end
                n_rem         = 2'd0;
                n_acc         = '0;
                n_kind        = K_IDLE;
                o_job.has_end = 1'b1;
            end
        end
        o_push = w_accept && !r_ended && (o_job.has_char || o_job.has_end);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_EUC_JK;
            r_rem   <= 2'd0;
            r_acc   <= '0;
            r_kind  <= K_IDLE;
            r_ended <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= t_mode'(i_cfg_data);
            end
            if (w_accept) begin
                r_rem   <= n_rem;
                r_acc   <= n_acc;
                r_kind  <= n_kind;
                r_ended <= n_ended;
            end
        end
    end

endmodule

>>> rtl/mtwc_queue.sv
module mtwc_queue
    import mtwc_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_head
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_do_push;
    logic          w_do_pop;

    function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_head    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (w_do_pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

>>> rtl/mtwc_back.sv
module mtwc_back
    import mtwc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  t_job              i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [CODE_W-1:0] o_code,
    output logic              o_is_end,
    output logic              o_truncated
);

    logic              r_phase;
    logic              r_valid;
    logic [CODE_W-1:0] r_code;
    logic              r_is_end;
    logic              r_trunc;
    logic              w_load;
    logic              w_char_beat;
    logic              w_last;

    assign w_load      = !i_empty && (!r_valid || !i_stall);
    assign w_char_beat = i_head.has_char && !r_phase;
    assign w_last      = w_char_beat ? !i_head.has_end : 1'b1;
    assign o_pop       = w_load && w_last;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_code   <= w_char_beat ? i_head.code : '0;
            r_is_end <= !w_char_beat;
            r_trunc  <= w_char_beat && i_head.truncated;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_phase <= !w_last;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_code      = r_code;
    assign o_is_end    = r_is_end;
    assign o_truncated = r_trunc;

endmodule

>>> rtl/multibyte_to_wide_char_decoder.sv
// Channel   Valid           Stall           Beat contents
// input     i_in_valid      o_in_stall      i_in_byte, i_end_of_buffer
// output    o_out_valid     i_out_stall     o_wide_code, o_is_end, o_truncated
// config    i_cfg_we        (none)          i_cfg_data
//
// One byte is taken per cycle unless the job queue is full; a result beat passes
// through the job queue and the output register. A byte that yields a character
// and end marker needs two beats; one beat per unstalled cycle sets the byte rate.
// Reset is synchronous and clears the decoder state, the job queue and the output.
// The input stalls only when the job queue is full, independent of output stalls.
module multibyte_to_wide_char_decoder
    import mtwc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BYTE_W-1:0] i_in_byte,
    input  logic              i_end_of_buffer,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [CODE_W-1:0] o_wide_code,
    output logic              o_is_end,
    output logic              o_truncated
);

    logic w_push;
    t_job w_job;
    logic w_full;
    logic w_empty;
    logic w_pop;
    t_job w_head;

    mtwc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_in_valid),
        .i_byte     (i_in_byte),
        .i_eob      (i_end_of_buffer),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_job      (w_job)
    );

    mtwc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    mtwc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_code      (o_wide_code),
        .o_is_end    (o_is_end),
        .o_truncated (o_truncated)
    );

    assign o_in_stall = w_full;

endmodule

>>> rtl/mtwc_checker.sv
module mtwc_checker
    import mtwc_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [CODE_W-1:0] o_wide_code,
    input logic              o_is_end,
    input logic              o_truncated
);

    // The end marker carries no code and is never flagged truncated.
    a_end_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_end) |-> (o_wide_code == '0) && !o_truncated)
        else $error("end marker carries code or truncation flag");

    // A truncated character is followed at once by its end marker.
    a_trunc_then_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_truncated) |=> (o_out_valid && o_is_end))
        else $error("truncated character not followed by end marker");

    // The output is empty in the first cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

    // A stalled beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_wide_code) && $stable(o_is_end)
             && $stable(o_truncated)))
        else $error("stalled output beat changed");

    // An offered input beat always sees a defined stall.
    a_stall_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid |-> !$isunknown(o_in_stall))
        else $error("input stall unknown while a beat is offered");

endmodule

bind multibyte_to_wide_char_decoder mtwc_checker u_mtwc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_wide_code (o_wide_code),
    .o_is_end    (o_is_end),
    .o_truncated (o_truncated)
);

>>> test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mtwc_pkg::*;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              is_end;
        logic              truncated;
    } t_char_beat;

    localparam int unsigned IDLE_LIMIT = 1000;
    localparam int unsigned LONG_HOLD = 80;

    class decode_scoreboard;
        t_mode             mode;
        logic [1:0]        owed;
        logic [CODE_W-1:0] partial;
        t_kind             kind;
        bit                ended;
        t_char_beat        expected_q[$];
        int unsigned       mismatches;

        function new();
            mode = MODE_EUC_JK;
            ended = 1'b0;
            mismatches = 0;
            clear_char();
        endfunction

        function void clear_char();
            owed = 2'd0;
            partial = '0;
            kind = K_IDLE;
        endfunction

        function void push_beat(logic [CODE_W-1:0] code, logic is_end, logic truncated);
            t_char_beat beat;
            beat.code = code;
            beat.is_end = is_end;
            beat.truncated = truncated;
            expected_q.push_back(beat);
        endfunction

        function logic [CODE_W-1:0] merge(logic [BYTE_W-1:0] b);
            logic [CODE_W-1:0] w;
            w = {16'h0000, b};
            case (kind)
                K_SS2_ONE, K_EUC2: return w;
                K_SS2_TW: return (owed == 2'd2) ? ((w << 8) & 24'h003F00) : w;
                K_SS2_CN: return (owed == 2'd3) ? (w << 16) : ((owed == 2'd2) ? (w << 8) : w);
                K_SS3: return (owed == 2'd2) ? (w << 8) : (w & 24'h00003F);
                K_UTF2: return w & 24'h00003F;
                K_UTF3: return (owed == 2'd2) ? ((w & 24'h00003F) << 6)
                                              : (w & 24'h00003F);
                default: return '0;
            endcase
        endfunction

        function void note_byte(logic [BYTE_W-1:0] b, logic eob);
            if (ended) begin
                if (eob) ended = 1'b0;
                return;
            end
            if (owed != 2'd0) begin
                partial = partial | merge(b);
                owed = owed - 2'd1;
                if (owed == 2'd0) begin
                    push_beat(partial, 1'b0, 1'b0);
                    clear_char();
                end
            end else if (b == 8'h00) begin
                push_beat('0, 1'b1, 1'b0);
                clear_char();
                if (!eob) ended = 1'b1;
                return;
            end else if (mode == MODE_UTF8) begin
                if (b[7] == 1'b0) begin
                    push_beat({16'h0000, b}, 1'b0, 1'b0);
                end else if (b[7:5] == 3'b110) begin
                    kind = K_UTF2;
                    owed = 2'd1;
                    partial = {16'h0000, b & 8'h1F} << 6;
                end else if (b[7:5] == 3'b111) begin
                    kind = K_UTF3;
                    owed = 2'd2;
                    partial = {16'h0000, b & 8'h0F} << 12;
                end
            end else if (b == SS2_BYTE) begin
                partial = '0;
                if (mode == MODE_EUC_JK) begin
                    kind = K_SS2_ONE;
                    owed = 2'd1;
                end else if (mode == MODE_EUC_TW) begin
                    kind = K_SS2_TW;
                    owed = 2'd2;
                end else begin
                    kind = K_SS2_CN;
                    owed = 2'd3;
                end
            end else if (b == SS3_BYTE) begin
                kind = K_SS3;
                owed = 2'd2;
                partial = '0;
            end else if (b[7]) begin
                kind = K_EUC2;
                owed = 2'd1;
                partial = {8'h00, b, 8'h00};
            end else begin
                push_beat({16'h0000, b}, 1'b0, 1'b0);
            end
            if (eob) begin
                if (owed != 2'd0) push_beat(partial, 1'b0, 1'b1);
                clear_char();
                push_beat('0, 1'b1, 1'b0);
            end
        endfunction

        function void check_beat(logic [CODE_W-1:0] code, logic is_end, logic truncated);
            t_char_beat want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: code %h end %b truncated %b",
                             code, is_end, truncated);
                return;
            end
            want = expected_q.pop_front();
            if (want.code !== code || want.is_end !== is_end || want.truncated !== truncated)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("beat mismatch: expected code %h end %b truncated %b, got %h %b %b",
                             want.code, want.is_end, want.truncated, code, is_end, truncated);
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [1:0]        i_cfg_data = 2'd0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [BYTE_W-1:0] i_in_byte = '0;
    logic              i_end_of_buffer = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [CODE_W-1:0] o_wide_code;
    logic              o_is_end;
    logic              o_truncated;

    decode_scoreboard  sb;
    logic [BYTE_W-1:0] buf_bytes[$];
    int unsigned       bytes_sent = 0;
    int unsigned       idle_cycles = 0;
    bit                send_eager = 1'b0;
    bit                recv_eager = 1'b0;
    bit                long_hold_req = 1'b0;

    multibyte_to_wide_char_decoder uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_byte       (i_in_byte),
        .i_end_of_buffer (i_end_of_buffer),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_wide_code     (o_wide_code),
        .o_is_end        (o_is_end),
        .o_truncated     (o_truncated)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eob);
        int unsigned gap;
        gap = send_eager ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte <= b;
        i_end_of_buffer <= eob;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        sb.note_byte(b, eob);
        bytes_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_mode(input t_mode m);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.mode = m;
    endtask

    function automatic logic [BYTE_W-1:0] any_byte();
        return ($urandom_range(0, 15) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [BYTE_W-1:0] cont_byte();
        return ($urandom_range(0, 7) == 0) ? any_byte() : (8'h80 | 8'($urandom_range(0, 63)));
    endfunction

    function automatic void push_char();
        int unsigned pick;
        logic [BYTE_W-1:0] lead;
        pick = $urandom_range(0, 9);
        if (sb.mode == MODE_UTF8) begin
            if (pick < 3) begin
                buf_bytes.push_back(8'($urandom_range(1, 127)));
            end else if (pick < 6) begin
                buf_bytes.push_back(8'hC0 | 8'($urandom_range(0, 31)));
                buf_bytes.push_back(cont_byte());
            end else if (pick < 9) begin
                buf_bytes.push_back(8'hE0 | 8'($urandom_range(0, 31)));
                buf_bytes.push_back(cont_byte());
                buf_bytes.push_back(cont_byte());
            end else begin
                buf_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
            end
        end else begin
            if (pick < 3) begin
                buf_bytes.push_back(8'($urandom_range(1, 127)));
            end else if (pick < 6) begin
                do lead = 8'($urandom_range(128, 255));
                while (lead == SS2_BYTE || lead == SS3_BYTE);
                buf_bytes.push_back(lead);
                buf_bytes.push_back(any_byte());
            end else if (pick < 8) begin
                buf_bytes.push_back(SS2_BYTE);
                repeat ((sb.mode == MODE_EUC_JK) ? 1 : ((sb.mode == MODE_EUC_TW) ? 2 : 3))
                    buf_bytes.push_back(any_byte());
            end else begin
                buf_bytes.push_back(SS3_BYTE);
                buf_bytes.push_back(any_byte());
                buf_bytes.push_back(any_byte());
            end
        end
    endfunction

    task automatic send_buffer(input bit open_end);
        int unsigned nchars;
        int unsigned base_len;
        int unsigned added;
        buf_bytes.delete();
        nchars = $urandom_range(1, 6);
        repeat (nchars) begin
            if ($urandom_range(0, 11) == 0) buf_bytes.push_back(8'h00);
            else push_char();
        end
        if ($urandom_range(0, 3) == 0) begin
            base_len = buf_bytes.size();
            push_char();
            added = buf_bytes.size() - base_len;
            if (added > 1)
                repeat ($urandom_range(1, added - 1)) void'(buf_bytes.pop_back());
        end
        foreach (buf_bytes[i])
            send_byte(buf_bytes[i], !open_end && (i == buf_bytes.size() - 1));
    endtask

    task automatic send_noise(input bit open_end);
        int unsigned n;
        n = $urandom_range(1, 8);
        for (int unsigned i = 0; i < n; i++)
            send_byte(8'($urandom_range(0, 255)), !open_end && (i == n - 1));
    endtask

    initial begin : result_sink
        int unsigned hold;
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
            end else if (recv_eager) begin
                hold = 0;
            end else begin
                hold = $urandom_range(0, 14);
            end
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_beat(o_wide_code, o_is_end, o_truncated);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
            $display("testbench NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int unsigned nbuf;
        bit open_end;
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_mode(MODE_EUC_JK);
        send_byte(8'hB0, 1'b0);
        send_byte(8'hA1, 1'b0);
        send_byte(SS2_BYTE, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(SS3_BYTE, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h80, 1'b1);
        set_mode(MODE_UTF8);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'h80, 1'b1);
        set_mode(MODE_EUC_TW);
        send_byte(SS2_BYTE, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        set_mode(MODE_EUC_CN);
        send_byte(SS3_BYTE, 1'b1);
        send_byte(SS2_BYTE, 1'b0);
        send_byte(8'h12, 1'b1);
        send_byte(8'hA1, 1'b0);
        // The pending two-byte character must finish under its EUC kind.
        set_mode(MODE_UTF8);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b1);

        // Hold the output back while bytes keep coming so the input stalls.
        wait_idle();
        send_eager = 1'b1;
        long_hold_req = 1'b1;
        for (int unsigned i = 0; i < 40; i++)
            send_byte(8'($urandom_range(1, 127)), i == 39);
        send_eager = 1'b0;

        while (bytes_sent < 800) begin
            set_mode(t_mode'($urandom_range(0, 3)));
            send_eager = ($urandom_range(0, 3) == 0);
            recv_eager = ($urandom_range(0, 3) == 0);
            nbuf = $urandom_range(2, 6);
            for (int unsigned k = 0; k < nbuf; k++) begin
                open_end = (k == nbuf - 1) && ($urandom_range(0, 2) == 0);
                if ($urandom_range(0, 4) == 0) send_noise(open_end);
                else send_buffer(open_end);
            end
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("testbench OK");
        end else begin
            $display("%0d mismatches, %0d beats missing", sb.mismatches, sb.pending());
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule

>>> filelist.f
rtl/mtwc_pkg.sv
rtl/mtwc_front.sv
rtl/mtwc_queue.sv
rtl/mtwc_back.sv
rtl/multibyte_to_wide_char_decoder.sv
rtl/mtwc_checker.sv
test/testbench.sv
